// File: sv/dchr_pkg.sv
// ----------------------------------------------------------------------------
// dchr_pkg: shared types and constants for the haze recovery pipeline
// Pixel type, divider widths, stage payload structs and fixed scale factors.
// ----------------------------------------------------------------------------
package dchr_pkg;

	localparam int PIX_W   = 8;
	localparam int QBITS   = 8;
	localparam int TREM_W  = 18;
	localparam int TDIV_W  = 10;
	localparam int DEN_W   = 9;
	localparam int NUM_W   = 18;
	localparam int MAG_W   = 17;
	localparam int NUM_CH  = 3;

	localparam int T_STAGES   = QBITS;
	localparam int R_STAGES   = QBITS;
	localparam int R_BASE     = T_STAGES + 1;
	localparam int NUM_STAGES = R_BASE + R_STAGES + 1;

	localparam logic [PIX_W-1:0] AIRLIGHT_RST = 8'd255;
	localparam logic [PIX_W-1:0] T_LOW        = 8'd63;
	localparam logic [DEN_W-1:0] DEN_MIN      = 9'd51;
	localparam logic [NUM_W-1:0] RECOVER_GAIN = 18'd510;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t                          a;
		logic [NUM_CH-1:0][PIX_W-1:0]  pix;
		logic [TREM_W-1:0]             rem;
		logic [TDIV_W-1:0]             div;
		logic [QBITS-1:0]              q;
	} tst_t;

	typedef struct packed {
		pix_t                          t;
		logic [DEN_W-1:0]              den;
		logic [NUM_CH-1:0][MAG_W-1:0]  mag;
		logic [NUM_CH-1:0][QBITS-1:0]  q;
		logic [NUM_CH-1:0]             sat;
	} rst_t;

endpackage

// File: sv/dchr_if.sv
// ----------------------------------------------------------------------------
// dchr_if: pixel stream channels
// Hazy pixel input channel and dehazed pixel output channel, valid/ready.
// ----------------------------------------------------------------------------
interface dchr_in_if;
	import dchr_pkg::*;

	logic valid;
	logic ready;
	pix_t red;
	pix_t green;
	pix_t blue;
	pix_t dark_value;

	modport source (output valid, output red, output green, output blue,
		output dark_value, input ready);
	modport sink (input valid, input red, input green, input blue,
		input dark_value, output ready);
endinterface

interface dchr_out_if;
	import dchr_pkg::*;

	logic valid;
	logic ready;
	pix_t out_red;
	pix_t out_green;
	pix_t out_blue;
	pix_t transmission;

	modport source (output valid, output out_red, output out_green,
		output out_blue, output transmission, input ready);
	modport sink (input valid, input out_red, input out_green,
		input out_blue, input transmission, output ready);
endinterface

// File: sv/dark_channel_haze_recovery.sv
// ----------------------------------------------------------------------------
// dark_channel_haze_recovery: dark channel prior scene radiance recovery
// Transmission estimate from the dark value and airlight, then per-channel
// recovery (c - A) * 255 / t + A with magnitude and saturation at 255.
// ----------------------------------------------------------------------------
// Usage:
//   hazy     : input channel, one pixel (red, green, blue, dark_value) per
//              transfer.
//   dehazed  : output channel, one result (out_red, out_green, out_blue,
//              transmission) per transfer, in input order.
//   cfg_we / cfg_wdata : write the airlight register; write only while the
//              pipeline is empty.
// Throughput is one pixel per cycle while dehazed.ready is high: an input
// stage comes first, the transmission divider retires one quotient bit per
// stage over 8 stages, a numerator stage follows, and the three recovery
// dividers retire one bit per stage over 8 more.
// Reset empties the pipeline and sets the airlight to 255.
// When the receiver stalls, the result holds on the output and each stage
// keeps accepting until it meets a full stage ahead; empty stages fill, so
// up to 18 pixels are taken in before hazy.ready drops.
// ----------------------------------------------------------------------------
module dark_channel_haze_recovery (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  dchr_pkg::pix_t cfg_wdata,
	dchr_in_if.sink     hazy,
	dchr_out_if.source  dehazed
);
	import dchr_pkg::*;

	pix_t                    airlight_q;
	logic [NUM_STAGES-1:0]   v_q;
	logic [NUM_STAGES-1:0]   en;
	tst_t                    tst_s [0:T_STAGES];
	rst_t                    rst_s [0:R_STAGES];

	pix_t                    dc;
	logic [TDIV_W-1:0]       tdiff;
	logic [TREM_W-1:0]       tnum;

	pix_t                    p_t;
	logic [DEN_W-1:0]        p_den;
	logic [NUM_W-1:0]        p_aden;
	logic [NUM_W-1:0]        p_neg;
	logic [NUM_CH-1:0][NUM_W-1:0] p_pos;
	logic [NUM_CH-1:0][MAG_W-1:0] p_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			airlight_q <= AIRLIGHT_RST;
		end else if (cfg_we) begin
			airlight_q <= cfg_wdata;
		end
	end

	// advance a stage when it is empty or the stage ahead advances
	assign en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || dehazed.ready;
	for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	assign hazy.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= hazy.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// input stage: clamp dark value, form 255 * (4A - 3d) over 4A
	always_comb begin
		dc    = (hazy.dark_value > airlight_q) ? airlight_q : hazy.dark_value;
		tdiff = {airlight_q, 2'b00} - ({1'b0, dc, 1'b0} + {2'b00, dc});
		tnum  = {tdiff, 8'b0} - {{(TREM_W-TDIV_W){1'b0}}, tdiff};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tst_s[0].a   <= airlight_q;
			tst_s[0].pix <= {hazy.red, hazy.green, hazy.blue};
			tst_s[0].rem <= tnum;
			tst_s[0].div <= {airlight_q, 2'b00};
			tst_s[0].q   <= '0;
		end
	end

	// transmission divider, one quotient bit per stage
	for (genvar j = 1; j <= T_STAGES; j++) begin : g_tdiv
		localparam int K = QBITS - j;
		logic [TREM_W-1:0] sh;
		tst_t              nxt;

		assign sh = {{(TREM_W-TDIV_W){1'b0}}, tst_s[j-1].div} << K;

		always_comb begin
			nxt = tst_s[j-1];
			if (tst_s[j-1].rem >= sh) begin
				nxt.rem  = tst_s[j-1].rem - sh;
				nxt.q[K] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				tst_s[j] <= nxt;
			end
		end
	end

	// numerator stage: |(c - A) * 510 + A * den|
	always_comb begin
		p_t    = tst_s[T_STAGES].q;
		p_den  = {p_t, 1'b0};
		if (p_den < DEN_MIN) begin
			p_den = DEN_MIN;
		end
		p_aden = NUM_W'(tst_s[T_STAGES].a) * NUM_W'(p_den);
		p_neg  = NUM_W'(tst_s[T_STAGES].a) * RECOVER_GAIN;
		for (int c = 0; c < NUM_CH; c++) begin
			p_pos[c] = NUM_W'(tst_s[T_STAGES].pix[c]) * RECOVER_GAIN + p_aden;
			p_mag[c] = (p_pos[c] >= p_neg) ? MAG_W'(p_pos[c] - p_neg)
			                               : MAG_W'(p_neg - p_pos[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[R_BASE]) begin
			rst_s[0].t   <= p_t;
			rst_s[0].den <= p_den;
			rst_s[0].mag <= p_mag;
			rst_s[0].q   <= '0;
			rst_s[0].sat <= '0;
		end
	end

	// recovery dividers, one quotient bit per stage, saturation on the first
	for (genvar j = 1; j <= R_STAGES; j++) begin : g_rdiv
		localparam int K = QBITS - j;
		logic [MAG_W-1:0] sh;
		logic [MAG_W-1:0] lim;
		rst_t             nxt;

		assign sh  = {{(MAG_W-DEN_W){1'b0}}, rst_s[j-1].den} << K;
		assign lim = {rst_s[j-1].den, 8'b0};

		always_comb begin
			nxt = rst_s[j-1];
			for (int c = 0; c < NUM_CH; c++) begin
				if (rst_s[j-1].mag[c] >= sh) begin
					nxt.mag[c]  = rst_s[j-1].mag[c] - sh;
					nxt.q[c][K] = 1'b1;
				end
				if (j == 1) begin
					nxt.sat[c] = (rst_s[j-1].mag[c] >= lim);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[R_BASE+j]) begin
				rst_s[j] <= nxt;
			end
		end
	end

	assign dehazed.valid        = v_q[NUM_STAGES-1];
	assign dehazed.out_red      = rst_s[R_STAGES].sat[2] ? 8'hFF : rst_s[R_STAGES].q[2];
	assign dehazed.out_green    = rst_s[R_STAGES].sat[1] ? 8'hFF : rst_s[R_STAGES].q[1];
	assign dehazed.out_blue     = rst_s[R_STAGES].sat[0] ? 8'hFF : rst_s[R_STAGES].q[0];
	assign dehazed.transmission = rst_s[R_STAGES].t;

	a_t_floor: assert property (@(posedge clk) disable iff (!arst_n)
		dehazed.valid |-> dehazed.transmission >= T_LOW)
		else $error("transmission below clamp floor");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		hazy.valid && hazy.ready |=> v_q[0])
		else $error("input transfer not captured");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] && !en[0] |=> v_q[0] && $stable(tst_s[0]))
		else $error("stalled input stage changed");

	a_tdiv: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[T_STAGES] && tst_s[T_STAGES].div != '0 |->
		tst_s[T_STAGES].rem < {{(TREM_W-TDIV_W){1'b0}}, tst_s[T_STAGES].div})
		else $error("transmission remainder not below divisor");

	a_rdiv: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NUM_STAGES-1] && !rst_s[R_STAGES].sat[0] |->
		rst_s[R_STAGES].mag[0] < {{(MAG_W-DEN_W){1'b0}}, rst_s[R_STAGES].den})
		else $error("recovery remainder not below divisor");

endmodule
